// ----- sv/fhrp_pkg.sv -----
// ----------------------------------------------------------------------------
// fhrp_pkg
// Shared widths, reset values, item codes, status codes and configuration
// indices of the frame history and refresh predictor.
// ----------------------------------------------------------------------------
package fhrp_pkg;

  localparam int unsigned TimeW   = 62;
  localparam int unsigned IntvW   = 20;
  localparam int unsigned FrameW  = 63;
  localparam int unsigned AgeW    = 24;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned EntryW  = TimeW + IntvW;
  localparam int unsigned DivCntW = 6;

  localparam logic [IntvW-1:0] DefIntvReset = 20'd16667;
  localparam logic [AgeW-1:0]  MaxAgeReset  = 24'd150000;

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_RECORD  = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_PREDICT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_NOTIME = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_DEF_INTERVAL = 2'd0,
    CFG_MAX_AGE      = 2'd1
  } cfg_idx_t;

endpackage

// ----- sv/fhrp_hist_mem.sv -----
// ----------------------------------------------------------------------------
// fhrp_hist_mem
// History ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fhrp_hist_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [fhrp_pkg::EntryW-1:0]   wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [fhrp_pkg::EntryW-1:0]   rdata
);

  logic [fhrp_pkg::EntryW-1:0] mem [DEPTH];

  // write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read entry into registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/fhrp_rem_div.sv -----
// ----------------------------------------------------------------------------
// fhrp_rem_div
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module fhrp_rem_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fhrp_pkg::TimeW-1:0]  dividend,
  input  logic [fhrp_pkg::IntvW-1:0]  divisor,
  output logic                        done,
  output logic [fhrp_pkg::IntvW-1:0]  rem
);

  localparam logic [fhrp_pkg::DivCntW-1:0] LastCnt =
    fhrp_pkg::DivCntW'(fhrp_pkg::TimeW - 1);

  logic                          busy_r;
  logic [fhrp_pkg::DivCntW-1:0]  cnt_r;
  logic [fhrp_pkg::TimeW-1:0]    num_r;
  logic [fhrp_pkg::IntvW-1:0]    den_r;
  logic [fhrp_pkg::IntvW-1:0]    rem_r;
  logic                          done_r;
  logic [fhrp_pkg::IntvW:0]      trial;
  logic [fhrp_pkg::IntvW:0]      diff;

  // shift in next dividend bit and try subtract
  always_comb begin
    trial = {rem_r, num_r[fhrp_pkg::TimeW-1]};
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= dividend;
        den_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[fhrp_pkg::TimeW-2:0], 1'b0};
        if (trial >= {1'b0, den_r}) begin
          rem_r <= diff[fhrp_pkg::IntvW-1:0];
        end else begin
          rem_r <= trial[fhrp_pkg::IntvW-1:0];
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LastCnt) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- sv/frame_history_refresh_predictor.sv -----
// ----------------------------------------------------------------------------
// frame_history_refresh_predictor
// Ring of recent frame timings with lookup, record and refresh prediction.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------
//  input    | in_op, in_frame_number, in_*_in, base   | start & !busy
//  result   | out_status, out_*                       | out_valid, 1 cycle
//  config   | cfg_we, cfg_addr, cfg_wdata             | cfg_we
//
//  Begin and record: result in the cycle after the item, busy stays low.
//  Lookup: one memory read into the registered read data, then the result register.
//  Predict: walk of older entries, newest first, at one memory read a cycle,
//  then the remainder unit when the time is advanced.
//  Reset is synchronous; history entries are cleared only by begin items.
//  The receiver takes every result; there is no output stall.
// ----------------------------------------------------------------------------
module frame_history_refresh_predictor #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_op,
  input  logic signed [62:0]            in_frame_number,
  input  logic [61:0]                   in_presentation_time_in,
  input  logic [19:0]                   in_refresh_interval_in,
  input  logic [61:0]                   in_base_time,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [61:0]                   out_presentation_time_out,
  output logic [19:0]                   out_refresh_interval_out,
  output logic signed [62:0]            out_frame_counter_out,
  output logic signed [62:0]            out_history_start_out,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [23:0]                   cfg_wdata
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned VW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned TW = fhrp_pkg::TimeW;
  localparam int unsigned IW = fhrp_pkg::IntvW;
  localparam int unsigned FW = fhrp_pkg::FrameW;
  localparam logic [AW-1:0] LastPos = AW'(HISTORY_DEPTH - 1);
  localparam logic [VW-1:0] FullCnt = VW'(HISTORY_DEPTH);
  localparam logic [TW-1:0] TimeMax = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_WALK,
    S_DIV
  } state_t;

  // ring position minus an offset below the depth
  function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] p,
                                             input logic [AW-1:0] b);
    logic [AW:0] t;
    if (p >= b) begin
      t = {1'b0, p} - {1'b0, b};
    end else begin
      t = {1'b0, p} + (AW+1)'(HISTORY_DEPTH) - {1'b0, b};
    end
    return t[AW-1:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [IW-1:0]      def_intv_r;
  logic [23:0]        max_age_r;
  logic [FW-1:0]      fc_r, fc_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [VW-1:0]      vcnt_r, vcnt_nxt;
  logic [IW-1:0]      carry_r, carry_nxt;
  logic signed [63:0] limit_r, limit_nxt;
  logic [TW-1:0]      base_r, base_nxt;
  logic [VW-1:0]      k_r, k_nxt;
  logic               dv_r, dv_nxt;
  logic [IW-1:0]      iv_r, iv_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [TW-1:0]      out_pt_r, out_pt_nxt;
  logic [IW-1:0]      out_iv_r, out_iv_nxt;
  logic [FW-1:0]      out_fc_r, out_fc_nxt;
  logic [FW-1:0]      out_hs_r, out_hs_nxt;

  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [fhrp_pkg::EntryW-1:0] mem_wdata, mem_rdata;
  logic [TW-1:0]             rd_pt;
  logic [IW-1:0]             rd_iv;

  logic                div_start, div_done;
  logic [TW-1:0]       div_num;
  logic [IW-1:0]       div_den;
  logic [IW-1:0]       div_rem;

  logic                accept;
  logic signed [63:0]  frame_s, fc_s, back;
  logic                hit;
  logic [AW-1:0]       slot;
  logic [IW-1:0]       ev_iv;
  logic [TW:0]         adv_sum;

  assign accept = start && !busy;
  assign rd_pt  = mem_rdata[fhrp_pkg::EntryW-1:IW];
  assign rd_iv  = mem_rdata[IW-1:0];

  // history membership of the addressed frame
  always_comb begin
    frame_s = {in_frame_number[FW-1], in_frame_number};
    fc_s    = {fc_r[FW-1], fc_r};
    back    = fc_s - frame_s;
    hit     = (frame_s <= fc_s) && (back < 64'(vcnt_r));
    slot    = ring_sub(pos_r, back[AW-1:0]);
  end

  // next state, memory accesses and result
  always_comb begin
    ev_iv   = (rd_iv == '0) ? carry_r : rd_iv;
    adv_sum = {1'b0, base_r} + (TW+1)'(iv_r) - (TW+1)'(div_rem);
    state_nxt = state_r;
    fc_nxt    = fc_r;
    pos_nxt   = pos_r;
    vcnt_nxt  = vcnt_r;
    carry_nxt = carry_r;
    limit_nxt = limit_r;
    base_nxt  = base_r;
    k_nxt     = k_r;
    dv_nxt    = 1'b0;
    iv_nxt    = iv_r;
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = {in_presentation_time_in, in_refresh_interval_in};
    mem_re    = 1'b0;
    mem_raddr = slot;
    div_start = 1'b0;
    div_num   = base_r - rd_pt;
    div_den   = ev_iv;
    out_valid_nxt  = 1'b0;
    out_status_nxt = fhrp_pkg::ST_OK;
    out_pt_nxt     = '0;
    out_iv_nxt     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (fhrp_pkg::op_t'(in_op))
            fhrp_pkg::OP_BEGIN: begin
              fc_nxt    = fc_r + 1'b1;
              pos_nxt   = (pos_r == LastPos) ? '0 : pos_r + 1'b1;
              vcnt_nxt  = (vcnt_r < FullCnt) ? vcnt_r + 1'b1 : vcnt_r;
              mem_we    = 1'b1;
              mem_waddr = pos_nxt;
              mem_wdata = '0;
              out_valid_nxt = 1'b1;
            end
            fhrp_pkg::OP_RECORD: begin
              out_valid_nxt = 1'b1;
              if (hit) begin
                mem_we     = 1'b1;
                out_pt_nxt = in_presentation_time_in;
                out_iv_nxt = in_refresh_interval_in;
              end else begin
                out_status_nxt = fhrp_pkg::ST_MISS;
              end
            end
            fhrp_pkg::OP_LOOKUP: begin
              if (hit) begin
                mem_re    = 1'b1;
                state_nxt = S_LOOK;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = fhrp_pkg::ST_MISS;
              end
            end
            fhrp_pkg::OP_PREDICT: begin
              carry_nxt = def_intv_r;
              limit_nxt = $signed({2'b00, in_base_time}) - $signed({40'd0, max_age_r});
              base_nxt  = in_base_time;
              k_nxt     = '0;
              state_nxt = S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        out_valid_nxt = 1'b1;
        out_pt_nxt    = rd_pt;
        out_iv_nxt    = rd_iv;
        state_nxt     = S_IDLE;
      end
      S_WALK: begin
        if (dv_r && rd_pt != '0) begin
          // walk stops at the first known time
          carry_nxt = ev_iv;
          if ($signed({2'b00, rd_pt}) > limit_r) begin
            if (rd_pt < base_r && ev_iv != '0) begin
              iv_nxt    = ev_iv;
              div_start = 1'b1;
              state_nxt = S_DIV;
            end else begin
              out_valid_nxt = 1'b1;
              out_pt_nxt    = rd_pt;
              out_iv_nxt    = ev_iv;
              state_nxt     = S_IDLE;
            end
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = fhrp_pkg::ST_NOTIME;
            out_iv_nxt     = ev_iv;
            state_nxt      = S_IDLE;
          end
        end else begin
          if (dv_r) begin
            carry_nxt = ev_iv;
          end
          if (k_r < vcnt_r) begin
            // issue read of the next older entry
            mem_re    = 1'b1;
            mem_raddr = ring_sub(pos_r, k_r[AW-1:0]);
            k_nxt     = k_r + 1'b1;
            dv_nxt    = 1'b1;
          end else if (!dv_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = fhrp_pkg::ST_NOTIME;
            out_iv_nxt     = carry_r;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          out_iv_nxt    = iv_r;
          if (div_rem == '0) begin
            out_pt_nxt = base_r;
          end else if (adv_sum[TW]) begin
            out_pt_nxt = TimeMax;
          end else begin
            out_pt_nxt = adv_sum[TW-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_fc_nxt = fc_nxt;
    out_hs_nxt = fc_nxt + 1'b1 - FW'(vcnt_nxt);
  end

  // hold state, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      def_intv_r  <= fhrp_pkg::DefIntvReset;
      max_age_r   <= fhrp_pkg::MaxAgeReset;
      fc_r        <= '1;
      pos_r       <= LastPos;
      vcnt_r      <= '0;
      dv_r        <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      pos_r       <= pos_nxt;
      vcnt_r      <= vcnt_nxt;
      dv_r        <= dv_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_addr == fhrp_pkg::CFG_DEF_INTERVAL) begin
          def_intv_r <= cfg_wdata[IW-1:0];
        end else if (cfg_addr == fhrp_pkg::CFG_MAX_AGE) begin
          max_age_r <= cfg_wdata;
        end
      end
    end
    carry_r      <= carry_nxt;
    limit_r      <= limit_nxt;
    base_r       <= base_nxt;
    iv_r         <= iv_nxt;
    out_status_r <= out_status_nxt;
    out_pt_r     <= out_pt_nxt;
    out_iv_r     <= out_iv_nxt;
    out_fc_r     <= out_fc_nxt;
    out_hs_r     <= out_hs_nxt;
  end

  fhrp_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fhrp_rem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign busy                      = (state_r != S_IDLE);
  assign out_valid                 = out_valid_r;
  assign out_status                = out_status_r;
  assign out_presentation_time_out = out_pt_r;
  assign out_refresh_interval_out  = out_iv_r;
  assign out_frame_counter_out     = out_fc_r;
  assign out_history_start_out     = out_hs_r;

`ifndef NO_ASSERTIONS
  a_vcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= FullCnt)
    else $error("valid count beyond ring depth");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("remainder done outside divide state");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == fhrp_pkg::ST_OK || out_status == fhrp_pkg::ST_MISS ||
                   out_status == fhrp_pkg::ST_NOTIME))
    else $error("reserved status code on result");

  a_predict_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == fhrp_pkg::OP_PREDICT) |=> busy && !out_valid)
    else $error("predict item did not enter walk");
`endif

endmodule
